### rtl/core/gdfw_pkg.sv
// Package for the depth-first graph walk block.
// Holds the payload structs, the command and status structs and shared constants.
// No dependencies.
package gdfw_pkg;

  // Default vertex count and the fixed width of a vertex field.
  localparam int NumVerticesDef = 16;
  localparam int VertexW        = 4;

  // Operation codes carried in the func field.
  typedef enum logic {
    FUNC_ADD_EDGE = 1'b0,
    FUNC_SEARCH   = 1'b1
  } func_e;

  // Input transaction payload.
  typedef struct packed {
    logic               func;
    logic [VertexW-1:0] from_vertex;
    logic [VertexW-1:0] to_vertex;
  } gdfw_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [VertexW-1:0] visited_vertex;
    logic               last;
  } gdfw_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;    // clear one entry of the edge and count stores
    logic accept;      // latch the input transaction
    logic ins_read;    // read edge flag and neighbor count for an insert
    logic ins_write;   // append the edge if it is new and the row has room
    logic srch_init;   // reset visited marks, mark and hold the start vertex
    logic walk_start;  // load the start vertex as the stack top
    logic nbr_read;    // take the next untried neighbor of the stack top
    logic pop;         // drop the stack top and read the entry below
    logic pop_load;    // load the entry read by pop as the new top
    logic visit;       // send the held vertex, hold the new one, fetch its count
    logic push;        // push the new vertex with its neighbor count
    logic emit_last;   // send the held vertex as the final result
  } gdfw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;    // clearing pass finished
    logic is_search;   // latched transaction is a search
    logic in_range;    // latched vertices are inside the graph
    logic top_empty;   // stack top has no untried neighbors
    logic sp_one;      // stack holds a single entry
    logic w_new;       // fetched neighbor has not been visited
    logic out_free;    // output register can take a result this cycle
  } gdfw_stat_t;

endpackage

### rtl/core/graph_depth_first_walk_top.sv
// Top level of the depth-first graph walk block.
// Joins gdfw_ctrl and gdfw_datapath; depends on gdfw_pkg.
//
// Usage: the input channel (in_valid_i, in_stall_o, in_data_i) takes one
// transaction at a time. An add-edge transaction appends a neighbor to the
// source vertex's list unless the edge already exists or the row is full;
// it gives no result. A search transaction gives one
// result per vertex reachable from the start vertex in depth-first preorder,
// newest-inserted neighbors first, with last set on the final one. A search
// from a vertex outside the graph gives no result.
// The first result leaves after the second vertex is found or the walk
// ends, since the last flag is only known then.
// After reset the block sweeps the edge and count stores, one entry a cycle,
// and holds in_stall_o high until the sweep is done.
// The result register holds its transaction while out_stall_i is high; the
// walk pauses at the next found vertex until the register frees up.
module graph_depth_first_walk_top #(
  parameter int NUM_VERTICES = gdfw_pkg::NumVerticesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  gdfw_pkg::gdfw_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gdfw_pkg::gdfw_out_t  out_data_o
);
  import gdfw_pkg::*;

  gdfw_cmd_t  cmd;
  gdfw_stat_t stat;

  // Sequencer.
  gdfw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Stores, stack and output register.
  gdfw_datapath #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/core/gdfw_ctrl.sv
// Controller state machine for the depth-first graph walk block.
// Sequences the clearing pass, edge inserts and the walk; depends on gdfw_pkg.
module gdfw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  gdfw_pkg::gdfw_stat_t  stat_i,
  output gdfw_pkg::gdfw_cmd_t   cmd_o
);
  import gdfw_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_CHK,
    ST_S_START,
    ST_TOP,
    ST_NBR,
    ST_POP_WAIT,
    ST_CNT,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;

  // Input is taken only while idle.
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_done) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.clr_step = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!stat_i.in_range) begin
          state_d = ST_IDLE;
        end else if (stat_i.is_search) begin
          cmd_o.srch_init = 1'b1;
          state_d         = ST_S_START;
        end else begin
          cmd_o.ins_read = 1'b1;
          state_d        = ST_INS_CHK;
        end
      end
      ST_INS_CHK: begin
        cmd_o.ins_write = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_S_START: begin
        cmd_o.walk_start = 1'b1;
        state_d          = ST_TOP;
      end
      ST_TOP: begin
        if (!stat_i.top_empty) begin
          cmd_o.nbr_read = 1'b1;
          state_d        = ST_NBR;
        end else if (stat_i.sp_one) begin
          state_d = ST_FLUSH;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = ST_POP_WAIT;
        end
      end
      ST_NBR: begin
        if (!stat_i.w_new) begin
          state_d = ST_TOP;
        end else if (stat_i.out_free) begin
          cmd_o.visit = 1'b1;
          state_d     = ST_CNT;
        end
      end
      ST_POP_WAIT: begin
        cmd_o.pop_load = 1'b1;
        state_d        = ST_TOP;
      end
      ST_CNT: begin
        cmd_o.push = 1'b1;
        state_d    = ST_TOP;
      end
      ST_FLUSH: begin
        if (stat_i.out_free) begin
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/gdfw_datapath.sv
// Datapath for the depth-first graph walk block: graph stores, walk stack,
// visited marks and the output register; depends on gdfw_pkg.
module gdfw_datapath #(
  parameter int NUM_VERTICES = gdfw_pkg::NumVerticesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gdfw_pkg::gdfw_in_t    in_data_i,
  input  gdfw_pkg::gdfw_cmd_t   cmd_i,
  output gdfw_pkg::gdfw_stat_t  stat_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output gdfw_pkg::gdfw_out_t   out_data_o
);
  import gdfw_pkg::*;

  localparam int IW    = $clog2(NUM_VERTICES);
  localparam int CW    = $clog2(NUM_VERTICES + 1);
  localparam int Cells = NUM_VERTICES * NUM_VERTICES;
  localparam int AW    = $clog2(Cells);
  localparam int SW    = VertexW + CW;

  // Mark vector with only vertex zero set; shifted to mark the start vertex.
  localparam logic [NUM_VERTICES-1:0] StartMark = {{(NUM_VERTICES-1){1'b0}}, 1'b1};

  // Stores.
  logic               edge_mem  [Cells];
  logic [VertexW-1:0] list_mem  [Cells];
  logic [CW-1:0]      cnt_mem   [NUM_VERTICES];
  logic [SW-1:0]      stack_mem [NUM_VERTICES];

  // Registers.
  gdfw_in_t           item_q;
  logic [AW-1:0]      clr_q;
  logic               clr_done_q;
  logic               edge_rd_q;
  logic [VertexW-1:0] w_q;
  logic [CW-1:0]      cnt_rd_q;
  logic [SW-1:0]      stack_rd_q;
  logic [VertexW-1:0] top_v_q;
  logic [CW-1:0]      top_left_q;
  logic [CW-1:0]      sp_q;
  logic [VertexW-1:0] pend_q;
  logic [NUM_VERTICES-1:0] visited_q;
  logic               out_valid_q;
  gdfw_out_t          out_q;

  // Addresses and derived values.
  logic [AW-1:0] ins_addr;
  logic [AW-1:0] ins_list_addr;
  logic [AW-1:0] nbr_addr;
  logic [CW-1:0] top_slot;
  logic [IW-1:0] src_idx;
  logic [IW-1:0] w_idx;
  logic          row_room;
  logic          do_insert;
  logic          out_free;

  assign src_idx       = IW'(item_q.from_vertex);
  assign w_idx         = IW'(w_q);
  assign top_slot      = top_left_q - CW'(1);
  assign ins_addr      = AW'(item_q.from_vertex) * AW'(NUM_VERTICES)
                       + AW'(item_q.to_vertex);
  assign ins_list_addr = AW'(item_q.from_vertex) * AW'(NUM_VERTICES) + AW'(cnt_rd_q);
  assign nbr_addr      = AW'(top_v_q) * AW'(NUM_VERTICES) + AW'(top_slot);
  assign row_room      = (cnt_rd_q < CW'(NUM_VERTICES));
  assign do_insert     = cmd_i.ins_write && !edge_rd_q && row_room;
  assign out_free      = !out_valid_q || !out_stall_i;

  // Status toward the controller.
  always_comb begin
    stat_o.clr_done  = clr_done_q;
    stat_o.is_search = (item_q.func == FUNC_SEARCH);
    stat_o.in_range  = (32'(item_q.from_vertex) < NUM_VERTICES) &&
                       ((item_q.func == FUNC_SEARCH) ||
                        (32'(item_q.to_vertex) < NUM_VERTICES));
    stat_o.top_empty = (top_left_q == '0);
    stat_o.sp_one    = (sp_q == CW'(1));
    stat_o.w_new     = !visited_q[w_idx];
    stat_o.out_free  = out_free;
  end

  // Edge flag store: cleared by the pass after reset, read for duplicates.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      edge_mem[clr_q] <= 1'b0;
    end else if (do_insert) begin
      edge_mem[ins_addr] <= 1'b1;
    end
    if (cmd_i.ins_read) begin
      edge_rd_q <= edge_mem[ins_addr];
    end
  end

  // Neighbor list store: appended on insert, read one slot per walk step.
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      list_mem[ins_list_addr] <= item_q.to_vertex;
    end
    if (cmd_i.nbr_read) begin
      w_q <= list_mem[nbr_addr];
    end
  end

  // Neighbor count store: cleared in the pass, read for inserts, search starts and pushes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step && (32'(clr_q) < NUM_VERTICES)) begin
      cnt_mem[IW'(clr_q)] <= '0;
    end else if (do_insert) begin
      cnt_mem[src_idx] <= cnt_rd_q + CW'(1);
    end
    if (cmd_i.ins_read || cmd_i.srch_init) begin
      cnt_rd_q <= cnt_mem[src_idx];
    end else if (cmd_i.visit) begin
      cnt_rd_q <= cnt_mem[w_idx];
    end
  end

  // Walk stack below the top entry; the top lives in registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && (sp_q < CW'(NUM_VERTICES))) begin
      stack_mem[IW'(sp_q - CW'(1))] <= {top_v_q, top_left_q};
    end
    if (cmd_i.pop) begin
      stack_rd_q <= stack_mem[IW'(sp_q - CW'(2))];
    end
  end

  // Latched transaction and held vertex.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
    if (cmd_i.srch_init) begin
      pend_q <= item_q.from_vertex;
    end else if (cmd_i.visit) begin
      pend_q <= w_q;
    end
  end

  // Control registers: clearing pass, stack pointer, marks and output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      clr_done_q  <= 1'b0;
      top_v_q     <= '0;
      top_left_q  <= '0;
      sp_q        <= '0;
      visited_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        if (clr_q == AW'(Cells - 1)) begin
          clr_done_q <= 1'b1;
        end else begin
          clr_q <= clr_q + AW'(1);
        end
      end

      // Stack top and pointer.
      if (cmd_i.walk_start) begin
        top_v_q    <= item_q.from_vertex;
        top_left_q <= cnt_rd_q;
        sp_q       <= CW'(1);
      end else if (cmd_i.nbr_read) begin
        top_left_q <= top_slot;
      end else if (cmd_i.pop) begin
        sp_q <= sp_q - CW'(1);
      end else if (cmd_i.pop_load) begin
        {top_v_q, top_left_q} <= stack_rd_q;
      end else if (cmd_i.push && (sp_q < CW'(NUM_VERTICES))) begin
        top_v_q    <= w_q;
        top_left_q <= cnt_rd_q;
        sp_q       <= sp_q + CW'(1);
      end

      // Visited marks are reset at the start of every search.
      if (cmd_i.srch_init) begin
        visited_q <= StartMark << src_idx;
      end else if (cmd_i.visit) begin
        visited_q[w_idx] <= 1'b1;
      end

      // Output register; a vertex is sent once its successor or the end is known.
      if (cmd_i.visit) begin
        out_valid_q          <= 1'b1;
        out_q.visited_vertex <= pend_q;
        out_q.last           <= 1'b0;
      end else if (cmd_i.emit_last) begin
        out_valid_q          <= 1'b1;
        out_q.visited_vertex <= pend_q;
        out_q.last           <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
